// ===== design/cwu_pkg.sv =====
// ============================================================================
// cwu_pkg
// Shared types, codes and helpers for the clause watch update block.
// ============================================================================
package cwu_pkg;

  // Sizing
  localparam int MAX_LITS = 64;
  localparam int NUM_VARS = 1024;

  localparam int CMD_W = 2;
  localparam int LIT_W = 11;
  localparam int VAL_W = 2;
  localparam int ACT_W = 3;
  localparam int POS_W = 6;

  localparam int CL_AW = $clog2(MAX_LITS);
  localparam int LEN_W = $clog2(MAX_LITS + 1);
  localparam int VT_AW = $clog2(NUM_VARS);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FALSE = 2'd2;

  // Variable value codes
  localparam logic [VAL_W-1:0] VAL_UNASSIGNED = 2'd0;
  localparam logic [VAL_W-1:0] VAL_TRUE       = 2'd1;
  localparam logic [VAL_W-1:0] VAL_FALSE      = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ACK   = 3'd0,
    ACT_SAT   = 3'd1,
    ACT_WATCH = 3'd2,
    ACT_PROP  = 3'd3,
    ACT_ERR   = 3'd4
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [LIT_W-1:0]   lit;
    logic [POS_W-1:0]   pos;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_RD1,
    S_CHK,
    S_VAL,
    S_SCAN,
    S_WR0,
    S_WR1,
    S_WRI,
    S_RES
  } state_t;

  // True when the literal's variable lies inside the value table
  function automatic logic var_in_range(input logic [LIT_W-1:0] lit);
    return 32'(lit[LIT_W-1:1]) < NUM_VARS;
  endfunction

  // Value table address of the literal's variable
  function automatic logic [VT_AW-1:0] var_addr(input logic [LIT_W-1:0] lit);
    return VT_AW'(lit[LIT_W-1:1]);
  endfunction

  // Value of a literal from its variable's stored value and its sign
  function automatic logic [VAL_W-1:0] lit_value(input logic neg,
                                                 input logic [VAL_W-1:0] v,
                                                 input logic inr);
    logic [VAL_W-1:0] r;
    r = VAL_UNASSIGNED;
    if (inr) begin
      case (v)
        VAL_TRUE:  r = neg ? VAL_FALSE : VAL_TRUE;
        VAL_FALSE: r = neg ? VAL_TRUE : VAL_FALSE;
        default:   r = VAL_UNASSIGNED;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== design/cwu_if.sv =====
// ============================================================================
// cwu_in_if / cwu_out_if
// Valid/ready channels for command items and result items.
// ============================================================================
interface cwu_in_if import cwu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [LIT_W-1:0] lit_code;
  logic [VAL_W-1:0] var_value;
  logic             first;

  modport source (output valid, cmd, lit_code, var_value, first, input ready);
  modport sink   (input valid, cmd, lit_code, var_value, first, output ready);
endinterface

interface cwu_out_if import cwu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [LIT_W-1:0] out_literal;
  logic [POS_W-1:0] out_position;

  modport source (output valid, action, out_literal, out_position, input ready);
  modport sink   (input valid, action, out_literal, out_position, output ready);
endinterface

// ===== design/clause_watch_update.sv =====
// ============================================================================
// clause_watch_update
// One clause under the two-watched-literal scheme with a variable value
// table; output register decouples the result side from the sequencer.
// ============================================================================
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   cmd, lit_code, var_value, first
//  rsp      out  valid/ready   action, out_literal, out_position
//
//  Load, set, unknown and short-clause items pass from accept through the
//  dispatch and result states to the output register. A false-watch item
//  adds two clause reads, one value read, a scan of one clause entry per
//  cycle, then up to three write-backs before its result state.
//  After reset a clearing pass writes every value table entry to unassigned.
//  A stalled rsp holds the result; the next item is taken meanwhile.
//
module clause_watch_update import cwu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cwu_in_if.sink    req,
  cwu_out_if.source rsp
);

  res_t res;
  logic res_valid;
  logic res_ready;
  logic out_valid;
  res_t out_q;

  cwu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // Take a new result when the register is empty or being drained
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.action       = out_q.action;
  assign rsp.out_literal  = out_q.lit;
  assign rsp.out_position = out_q.pos;

endmodule

// ===== design/cwu_ram.sv =====
// ============================================================================
// cwu_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cwu_core.sv =====
// ============================================================================
// cwu_core
// Sequencer around the clause RAM and the value table RAM: executes one
// command item at a time and hands its result item to the output stage.
// ============================================================================
module cwu_core import cwu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cwu_in_if.sink     req,
  output res_t       res,
  output logic       res_valid,
  input  logic       res_ready
);

  state_t state, state_next;

  // Control registers
  logic [LEN_W-1:0] len;
  logic [VT_AW-1:0] clr_idx;
  logic [LEN_W-1:0] issue_idx;
  logic             p1v, p2v;
  logic             found;

  // Payload registers
  logic [CMD_W-1:0] cmd_r;
  logic [LIT_W-1:0] lit_r;
  logic [VAL_W-1:0] val_r;
  logic             first_r;
  logic [LIT_W-1:0] c0, w0, w1;
  logic             w0_inr;
  logic [CL_AW-1:0] p1_idx, p2_idx, f_idx;
  logic [LIT_W-1:0] p2_lit, f_lit;
  logic             p2_inr;
  res_t             res_r;

  // RAM ports
  logic             c_we;
  logic [CL_AW-1:0] c_waddr, c_raddr;
  logic [LIT_W-1:0] c_wdata, c_rdata;
  logic             v_we;
  logic [VT_AW-1:0] v_waddr, v_raddr;
  logic [VAL_W-1:0] v_wdata, v_rdata;

  cwu_ram #(.WIDTH(LIT_W), .DEPTH(MAX_LITS)) u_clause_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  cwu_ram #(.WIDTH(VAL_W), .DEPTH(NUM_VARS)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Decode helpers
  logic [LEN_W-1:0] load_base;
  logic             load_full;
  logic             set_ok;
  logic             short_cl;
  logic             hit0, hit1;
  logic [LIT_W-1:0] w0_sel, w1_sel;
  logic             sat;
  logic             issue_more;
  logic             p2_hit;
  logic             scan_done;
  logic             clr_last;
  action_t          disp_act;

  always_comb begin
    load_base  = first_r ? '0 : len;
    load_full  = load_base >= LEN_W'(MAX_LITS);
    set_ok     = (val_r == VAL_UNASSIGNED || val_r == VAL_TRUE || val_r == VAL_FALSE)
                 && var_in_range(lit_r);
    short_cl   = len < LEN_W'(2);
    hit0       = (c0 == lit_r);
    hit1       = (c_rdata == lit_r);
    w0_sel     = hit0 ? c_rdata : c0;
    w1_sel     = hit0 ? lit_r : c_rdata;
    sat        = lit_value(w0[0], v_rdata, w0_inr) == VAL_TRUE;
    issue_more = issue_idx < len;
    p2_hit     = p2v && (lit_value(p2_lit[0], v_rdata, p2_inr) != VAL_FALSE);
    scan_done  = !p1v && !p2v && !issue_more;
    clr_last   = clr_idx == VT_AW'(NUM_VARS - 1);
    // Result code of a load, a set or a rejected command
    case (cmd_r)
      CMD_LOAD: disp_act = load_full ? ACT_ERR : ACT_ACK;
      CMD_SET:  disp_act = set_ok ? ACT_ACK : ACT_ERR;
      default:  disp_act = ACT_ERR;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = S_DISP;
      S_DISP: begin
        if (cmd_r == CMD_FALSE && !short_cl) state_next = S_RD1;
        else state_next = S_RES;
      end
      S_RD1:   state_next = S_CHK;
      S_CHK:   state_next = (hit0 || hit1) ? S_VAL : S_RES;
      S_VAL:   state_next = sat ? S_RES : S_SCAN;
      S_SCAN:  if (p2_hit || scan_done) state_next = S_WR0;
      S_WR0:   state_next = S_WR1;
      S_WR1:   state_next = found ? S_WRI : S_RES;
      S_WRI:   state_next = S_RES;
      S_RES:   if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and RAM controls
  always_comb begin
    req.ready = 1'b0;
    res_valid = 1'b0;
    c_we      = 1'b0;
    c_waddr   = '0;
    c_wdata   = '0;
    c_raddr   = '0;
    v_we      = 1'b0;
    v_waddr   = '0;
    v_wdata   = VAL_UNASSIGNED;
    v_raddr   = '0;
    case (state)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_idx;
      end
      S_IDLE: req.ready = 1'b1;
      S_DISP: begin
        case (cmd_r)
          CMD_LOAD: begin
            c_we    = !load_full;
            c_waddr = load_base[CL_AW-1:0];
            c_wdata = lit_r;
          end
          CMD_SET: begin
            v_we    = set_ok;
            v_waddr = var_addr(lit_r);
            v_wdata = val_r;
          end
          default: c_raddr = '0;
        endcase
      end
      S_RD1: c_raddr = CL_AW'(1);
      S_CHK: v_raddr = var_addr(w0_sel);
      S_SCAN: begin
        c_raddr = issue_idx[CL_AW-1:0];
        v_raddr = var_addr(c_rdata);
      end
      S_WR0: begin
        c_we    = 1'b1;
        c_waddr = '0;
        c_wdata = w0;
      end
      S_WR1: begin
        c_we    = 1'b1;
        c_waddr = CL_AW'(1);
        c_wdata = found ? f_lit : w1;
      end
      S_WRI: begin
        c_we    = 1'b1;
        c_waddr = f_idx;
        c_wdata = w1;
      end
      S_RES: res_valid = 1'b1;
      default: req.ready = 1'b0;
    endcase
  end

  // Control registers: clause length, clearing pass, scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      clr_idx   <= '0;
      issue_idx <= '0;
      p1v       <= 1'b0;
      p2v       <= 1'b0;
      found     <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_DISP: begin
          if (cmd_r == CMD_LOAD && !load_full) len <= load_base + 1'b1;
        end
        S_VAL: begin
          issue_idx <= LEN_W'(2);
          p1v       <= 1'b0;
          p2v       <= 1'b0;
        end
        S_SCAN: begin
          if (issue_more) issue_idx <= issue_idx + 1'b1;
          p1v <= issue_more;
          p2v <= p1v;
          if (p2_hit) found <= 1'b1;
          else if (scan_done) found <= 1'b0;
        end
        default: p1v <= 1'b0;
      endcase
    end
  end

  // Payload registers: item fields, watches, scan data, result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r   <= req.cmd;
        lit_r   <= req.lit_code;
        val_r   <= req.var_value;
        first_r <= req.first;
      end
      S_DISP: res_r <= '{action: disp_act, lit: '0, pos: '0};
      S_RD1: c0 <= c_rdata;
      S_CHK: begin
        w0     <= w0_sel;
        w1     <= w1_sel;
        w0_inr <= var_in_range(w0_sel);
      end
      S_VAL: if (sat) res_r.action <= ACT_SAT;
      S_SCAN: begin
        p1_idx <= issue_idx[CL_AW-1:0];
        p2_idx <= p1_idx;
        p2_lit <= c_rdata;
        p2_inr <= var_in_range(c_rdata);
        if (p2_hit) begin
          f_idx <= p2_idx;
          f_lit <= p2_lit;
          res_r <= '{action: ACT_WATCH, lit: p2_lit, pos: POS_W'(p2_idx)};
        end else if (scan_done) begin
          res_r <= '{action: ACT_PROP, lit: w0, pos: '0};
        end
      end
      default: res_r <= res_r;
    endcase
  end

  assign res = res_r;

`ifndef SYNTHESIS
  // Clause length never passes the clause capacity
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_LITS))
    else $error("clause length beyond capacity");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("item accepted while another is in work");

  // Scan candidates come from positions two and up
  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && p2v |-> 32'(p2_idx) >= 2)
    else $error("scan candidate below position two");

  // Literal and position fields are zero unless a watch or propagate result
  a_res_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.action == ACT_WATCH || res.action == ACT_PROP)
                  || (res.lit == '0 && res.pos == '0))
    else $error("nonzero payload on plain result");
`endif

endmodule

// ===== bench/tb_clause_watch_update.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_clause_watch_update
// Self-checking bench for the two-watched-literal clause update block. A
// stimulus table covers reset state, error codes, the swap at position 0, the
// replacement scan, propagation and a literal watched twice. Random clause
// episodes follow: load a clause, assign variables, falsify a watch. Each
// accepted item runs through a local clause and value model. Results are
// matched in order, and both channels stall at random.
// ============================================================================
module tb_clause_watch_update;
  import cwu_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [VAL_W-1:0] VAL_BAD     = 2'd3;
  localparam logic [LIT_W-1:0] LIT_TOP     = {LIT_W{1'b1}};
  localparam int ITEM_COUNT  = 1750;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LIT_W-1:0] lit;
    logic [VAL_W-1:0] val;
    logic             first;
    logic             pinned;
    res_t             pin_res;
  } clause_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cwu_in_if  req_if ();
  cwu_out_if rsp_if ();

  clause_watch_update u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Model state: clause literals and variable values
  logic [LIT_W-1:0] clause_lits [MAX_LITS];
  int               clause_len;
  logic [VAL_W-1:0] var_vals    [NUM_VARS];

  res_t        pending_results [$];
  clause_cmd_t directed_tbl    [$];
  int          items_sent;
  int          mismatches;
  int          cycle_count;
  logic        req_calm;
  logic        rsp_calm;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Truth of a literal under the current assignment
  function automatic logic [VAL_W-1:0] literal_truth(input logic [LIT_W-1:0] l);
    int               vidx;
    logic [VAL_W-1:0] v;
    vidx = int'(l >> 1);
    if (vidx >= NUM_VARS) return VAL_UNASSIGNED;
    v = var_vals[vidx];
    if (v == VAL_TRUE)  return l[0] ? VAL_FALSE : VAL_TRUE;
    if (v == VAL_FALSE) return l[0] ? VAL_TRUE : VAL_FALSE;
    return VAL_UNASSIGNED;
  endfunction

  // Scan from position 2 for a non-false literal; swap it into position 1
  function automatic res_t find_watch();
    res_t             r;
    logic [LIT_W-1:0] t;
    r.action = ACT_PROP;
    r.lit    = clause_lits[0];
    r.pos    = '0;
    for (int i = 2; i < clause_len; i++) begin
      if (literal_truth(clause_lits[i]) != VAL_FALSE) begin
        t              = clause_lits[1];
        clause_lits[1] = clause_lits[i];
        clause_lits[i] = t;
        r.action       = ACT_WATCH;
        r.lit          = clause_lits[1];
        r.pos          = POS_W'(i);
        return r;
      end
    end
    return r;
  endfunction

  // Apply one command to the model and return the result it yields
  function automatic res_t watch_update_result(input clause_cmd_t it);
    res_t r;
    r.action = ACT_ERR;
    r.lit    = '0;
    r.pos    = '0;
    case (it.cmd)
      CMD_LOAD: begin
        if (it.first) clause_len = 0;
        if (clause_len < MAX_LITS) begin
          clause_lits[clause_len] = it.lit;
          clause_len++;
          r.action = ACT_ACK;
        end
      end
      CMD_SET: begin
        if (it.val <= VAL_FALSE && int'(it.lit >> 1) < NUM_VARS) begin
          var_vals[int'(it.lit >> 1)] = it.val;
          r.action = ACT_ACK;
        end
      end
      CMD_FALSE: begin
        if (clause_len >= 2) begin
          if (clause_lits[0] == it.lit) begin
            if (literal_truth(clause_lits[1]) == VAL_TRUE) begin
              r.action = ACT_SAT;
            end else begin
              clause_lits[0] = clause_lits[1];
              clause_lits[1] = it.lit;
              r = find_watch();
            end
          end else if (clause_lits[1] == it.lit) begin
            if (literal_truth(clause_lits[0]) == VAL_TRUE) r.action = ACT_SAT;
            else r = find_watch();
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic clause_cmd_t plain(input logic [CMD_W-1:0] c,
                                        input logic [LIT_W-1:0] l,
                                        input logic [VAL_W-1:0] v,
                                        input logic f);
    clause_cmd_t it;
    it.cmd     = c;
    it.lit     = l;
    it.val     = v;
    it.first   = f;
    it.pinned  = 1'b0;
    it.pin_res = '0;
    return it;
  endfunction

  function automatic clause_cmd_t pinned(input logic [CMD_W-1:0] c,
                                         input logic [LIT_W-1:0] l,
                                         input logic [VAL_W-1:0] v,
                                         input logic f,
                                         input action_t a);
    clause_cmd_t it;
    it                = plain(c, l, v, f);
    it.pinned         = 1'b1;
    it.pin_res.action = a;
    return it;
  endfunction

  // Literal over a small variable pool, sometimes anywhere in the code range
  function automatic logic [LIT_W-1:0] pool_lit();
    if ($urandom_range(0, 99) < 85) return LIT_W'($urandom_range(0, 31));
    return LIT_W'($urandom_range(0, 2047));
  endfunction

  // Drive one item, wait for acceptance, record its expected result
  task automatic send_cmd(input clause_cmd_t it);
    int   gap;
    res_t r;
    gap = 0;
    if ($urandom_range(0, 149) == 0) req_calm = !req_calm;
    if (!req_calm && $urandom_range(0, 99) < 40) gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= it.cmd;
    req_if.lit_code  <= it.lit;
    req_if.var_value <= it.val;
    req_if.first     <= it.first;
    do @(posedge clk); while (!req_if.ready);
    r = watch_update_result(it);
    pending_results.push_back(it.pinned ? it.pin_res : r);
    items_sent++;
  endtask

  // Load a fresh clause of n literals
  task automatic build_clause(input int n);
    for (int i = 0; i < n; i++) begin
      send_cmd(plain(CMD_LOAD, pool_lit(), VAL_W'($urandom_range(0, 3)), i == 0));
    end
  endtask

  // Assign some variables, then falsify a watch
  task automatic play_rounds(input int n_rounds);
    int               n_sets;
    logic [LIT_W-1:0] l;
    logic [LIT_W-1:0] w;
    repeat (n_rounds) begin
      n_sets = (clause_len > 8) ? $urandom_range(0, 12) : $urandom_range(0, 3);
      repeat (n_sets) begin
        if (clause_len > 0 && $urandom_range(0, 99) < 70)
          l = clause_lits[$urandom_range(0, clause_len - 1)];
        else
          l = pool_lit();
        if ($urandom_range(0, 99) < 60)
          send_cmd(plain(CMD_SET, l, l[0] ? VAL_TRUE : VAL_FALSE, 1'($urandom_range(0, 1))));
        else
          send_cmd(plain(CMD_SET, l, VAL_W'($urandom_range(0, 2)),
                         1'($urandom_range(0, 1))));
      end
      if (clause_len >= 2) begin
        w = clause_lits[$urandom_range(0, 1)];
        if ($urandom_range(0, 99) < 60)
          send_cmd(plain(CMD_SET, w, w[0] ? VAL_TRUE : VAL_FALSE, 1'b0));
      end else begin
        w = pool_lit();
      end
      if ($urandom_range(0, 99) < 5) w = pool_lit();
      send_cmd(plain(CMD_FALSE, w, VAL_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
    end
  endtask

  // Result side: random stalls with calm stretches
  initial begin : rsp_drive
    int hold_cnt;
    hold_cnt     = 0;
    rsp_calm     = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 499) == 0) rsp_calm = !rsp_calm;
      if (hold_cnt > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cnt--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!rsp_calm && $urandom_range(0, 99) < 20) hold_cnt = pick_gap();
      end
    end
  end

  // Check results in order; stop on the cycle limit
  always @(posedge clk) begin : result_check
    res_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_clause_watch_update: errors");
      $finish;
    end else if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: action %0d literal %0d position %0d",
                   rsp_if.action, rsp_if.out_literal, rsp_if.out_position);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.action !== want.action || rsp_if.out_literal !== want.lit ||
            rsp_if.out_position !== want.pos) begin
          if (mismatches < 10)
            $display("mismatch: action %0d/%0d literal %0d/%0d position %0d/%0d (exp/got)",
                     want.action, rsp_if.action, want.lit, rsp_if.out_literal,
                     want.pos, rsp_if.out_position);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_if.valid     <= 1'b0;
    req_if.cmd       <= CMD_LOAD;
    req_if.lit_code  <= '0;
    req_if.var_value <= VAL_UNASSIGNED;
    req_if.first     <= 1'b0;
    clause_len  = 0;
    items_sent  = 0;
    mismatches  = 0;
    cycle_count = 0;
    req_calm    = 1'b0;
    foreach (var_vals[i]) var_vals[i] = VAL_UNASSIGNED;
    foreach (clause_lits[i]) clause_lits[i] = '0;

    // Stimulus table: error paths, swap at position 0, scan, propagate
    directed_tbl.push_back(pinned(CMD_FALSE, 11'd0, VAL_UNASSIGNED, 1'b0, ACT_ERR));
    directed_tbl.push_back(pinned(CMD_UNKNOWN, LIT_TOP, VAL_BAD, 1'b1, ACT_ERR));
    directed_tbl.push_back(pinned(CMD_SET, LIT_TOP, VAL_BAD, 1'b0, ACT_ERR));
    directed_tbl.push_back(pinned(CMD_LOAD, LIT_TOP, VAL_UNASSIGNED, 1'b1, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_FALSE, LIT_TOP, VAL_UNASSIGNED, 1'b0, ACT_ERR));
    directed_tbl.push_back(pinned(CMD_LOAD, 11'd0, VAL_BAD, 1'b0, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_LOAD, 11'd4, VAL_UNASSIGNED, 1'b0, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_LOAD, 11'd7, VAL_UNASSIGNED, 1'b0, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_SET, 11'd2046, VAL_TRUE, 1'b0, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_FALSE, 11'd6, VAL_UNASSIGNED, 1'b0, ACT_ERR));
    directed_tbl.push_back(plain(CMD_FALSE, LIT_TOP, VAL_UNASSIGNED, 1'b0));
    directed_tbl.push_back(pinned(CMD_SET, 11'd0, VAL_TRUE, 1'b0, ACT_ACK));
    directed_tbl.push_back(plain(CMD_FALSE, 11'd4, VAL_UNASSIGNED, 1'b0));
    directed_tbl.push_back(pinned(CMD_SET, 11'd1, VAL_FALSE, 1'b1, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_SET, 11'd4, VAL_FALSE, 1'b0, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_SET, 11'd6, VAL_TRUE, 1'b0, ACT_ACK));
    directed_tbl.push_back(plain(CMD_FALSE, 11'd4, VAL_UNASSIGNED, 1'b0));
    directed_tbl.push_back(pinned(CMD_SET, 11'd2046, VAL_UNASSIGNED, 1'b0, ACT_ACK));
    directed_tbl.push_back(plain(CMD_FALSE, 11'd0, VAL_UNASSIGNED, 1'b0));
    directed_tbl.push_back(pinned(CMD_LOAD, 11'd10, VAL_UNASSIGNED, 1'b1, ACT_ACK));
    directed_tbl.push_back(pinned(CMD_LOAD, 11'd10, VAL_UNASSIGNED, 1'b0, ACT_ACK));
    directed_tbl.push_back(plain(CMD_FALSE, 11'd10, VAL_UNASSIGNED, 1'b0));
    directed_tbl.push_back(pinned(CMD_SET, 11'd10, VAL_TRUE, 1'b0, ACT_ACK));
    directed_tbl.push_back(plain(CMD_FALSE, 11'd10, VAL_UNASSIGNED, 1'b0));

    // Hold reset, then release
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_tbl[i]) send_cmd(directed_tbl[i]);

    // Fill the clause past capacity, then play on it
    build_clause(MAX_LITS + 2);
    play_rounds(6);

    // Random episodes: mostly well-formed, some noise
    while (items_sent < ITEM_COUNT) begin
      if ($urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 6)) begin
          send_cmd(plain(CMD_W'($urandom_range(0, 3)), LIT_W'($urandom_range(0, 2047)),
                         VAL_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        end
      end else begin
        if (clause_len < 2 || $urandom_range(0, 99) < 80) begin
          case ($urandom_range(0, 99)) inside
            [0:2]:   build_clause(MAX_LITS + $urandom_range(1, 3));
            [3:7]:   build_clause($urandom_range(9, MAX_LITS));
            [8:11]:  build_clause(1);
            default: build_clause($urandom_range(2, 8));
          endcase
        end
        play_rounds($urandom_range(1, 8));
      end
    end
    req_if.valid <= 1'b0;

    // Drain outstanding results, then allow stray ones to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_clause_watch_update: clean");
    end else begin
      $display("tb_clause_watch_update: errors");
    end
    $finish;
  end

endmodule
